### sv/prtp_pkg.sv
`timescale 1ns / 1ps

package prtp_pkg;

  // Register stages in the sine/cosine lookup: registered table read, then sign.
  localparam int ROM_LAT = 2;
  // Register stages in one plane rotation: products, then round and saturate.
  localparam int ROT_LAT = 2;
  // Edges from an accepted word to the edge that takes its result.
  localparam int PIPE_DEPTH = ROM_LAT + 2 * ROT_LAT;

endpackage

### sv/prtp_trig_rom.sv
`timescale 1ns / 1ps

module prtp_trig_rom #(
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic [ANGLE_BITS-1:0]            angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

  localparam int  QUARTER   = 2 ** (ANGLE_BITS - 2);
  localparam int  ROM_DEPTH = QUARTER + 1;
  localparam int  AW        = ANGLE_BITS - 1;
  localparam int  MW        = TRIG_FRAC_BITS + 1;
  localparam int  TW        = TRIG_FRAC_BITS + 2;
  localparam real PI        = 3.14159265358979323846;
  // Phase of one angle step, in radians.
  localparam real ANG_STEP  = 2.0 * PI / (2.0 ** ANGLE_BITS);

  typedef logic [MW-1:0] sine_tab_t [ROM_DEPTH];

  // Quarter wave of sine, rounded to nearest, scaled by 2^TRIG_FRAC_BITS.
  function automatic sine_tab_t build_tab();
    sine_tab_t t;
    real       ang;
    real       val;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      ang  = ANG_STEP * k;
      val  = $sin(ang) * (2.0 ** TRIG_FRAC_BITS) + 0.5;
      t[k] = MW'($rtoi(val));
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_tab();

  logic [1:0]            quad;
  logic [ANGLE_BITS-3:0] rem;
  logic [AW-1:0]         sin_addr;
  logic [AW-1:0]         cos_addr;
  logic [MW-1:0]         sin_mag_r;
  logic [MW-1:0]         cos_mag_r;
  logic                  sin_neg_r;
  logic                  cos_neg_r;
  logic signed [TW-1:0]  sin_r;
  logic signed [TW-1:0]  cos_r;

  // Odd quadrants read the table backwards; cosine is sine a quarter turn on.
  assign quad     = angle_i[ANGLE_BITS-1:ANGLE_BITS-2];
  assign rem      = angle_i[ANGLE_BITS-3:0];
  assign sin_addr = quad[0] ? AW'(QUARTER) - AW'(rem) : AW'(rem);
  assign cos_addr = quad[0] ? AW'(rem) : AW'(QUARTER) - AW'(rem);

  always_ff @(posedge clk) begin
    sin_mag_r <= SINE_TAB[sin_addr];
    cos_mag_r <= SINE_TAB[cos_addr];
    sin_neg_r <= quad[1];
    cos_neg_r <= quad[1] ^ quad[0];
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_neg_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    cos_r <= cos_neg_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

### sv/prtp_rot.sv
`timescale 1ns / 1ps

module prtp_rot #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  input  logic signed [COORD_BITS-1:0]     a_i,
  input  logic signed [COORD_BITS-1:0]     b_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_i,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_i,
  output logic                             vld_o,
  output logic signed [COORD_BITS-1:0]     p_o,
  output logic signed [COORD_BITS-1:0]     q_o
);

  // p = a*cos + b*sin and q = b*cos - a*sin, each rounded and saturated.
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = COORD_BITS + TW;
  localparam int SW = PW + 1;
  localparam int QW = SW - TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] HALF =
    {{(SW - TRIG_FRAC_BITS){1'b0}}, 1'b1, {(TRIG_FRAC_BITS - 1){1'b0}}};

  function automatic logic signed [COORD_BITS-1:0] round_sat(
    input logic signed [SW-1:0] s
  );
    logic signed [SW-1:0] w;
    logic [QW-1:0]        q;
    logic [COORD_BITS-1:0] res;
    w = s + HALF;
    q = w[SW-1:TRIG_FRAC_BITS];
    if (q[QW-1:COORD_BITS-1] == {(QW - COORD_BITS + 1){q[QW-1]}}) begin
      res = q[COORD_BITS-1:0];
    end else if (q[QW-1]) begin
      res = {1'b1, {(COORD_BITS - 1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS - 1){1'b1}}};
    end
    return $signed(res);
  endfunction

  logic                 vld1_r;
  logic                 vld2_r;
  logic signed [PW-1:0] pac_r;
  logic signed [PW-1:0] pbs_r;
  logic signed [PW-1:0] pbc_r;
  logic signed [PW-1:0] pas_r;
  logic signed [SW-1:0] sum_p;
  logic signed [SW-1:0] sum_q;
  logic signed [COORD_BITS-1:0] p_r;
  logic signed [COORD_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    pac_r <= PW'(a_i) * PW'(cos_i);
    pbs_r <= PW'(b_i) * PW'(sin_i);
    pbc_r <= PW'(b_i) * PW'(cos_i);
    pas_r <= PW'(a_i) * PW'(sin_i);
  end

  assign sum_p = SW'(pac_r) + SW'(pbs_r);
  assign sum_q = SW'(pbc_r) - SW'(pas_r);

  always_ff @(posedge clk) begin
    p_r <= round_sat(sum_p);
    q_r <= round_sat(sum_q);
  end

  assign vld_o = vld2_r;
  assign p_o   = p_r;
  assign q_o   = q_r;

endmodule

### sv/point_rotate_two_planes.sv
// A word accepted at one edge passes the lookup and both rotation registers; its
// result then shows on the out_ ports, marked by out_valid for one cycle, and the
// receiver takes it at the first edge that sees out_valid high.
// Throughput: one word per clock; busy stays low and start may be high every cycle.
// The receiver cannot stall; the pipeline has no back-pressure.
// Reset (rst_n low, synchronous) clears the valid bits; data registers are not reset.
`timescale 1ns / 1ps

module point_rotate_two_planes #(
  parameter int COORD_BITS     = 16,
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  input  logic [ANGLE_BITS-1:0]        in_angle_xz,
  input  logic [ANGLE_BITS-1:0]        in_angle_yz,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z
);

  // The datapath is a straight pipeline:
  //   two stages of sine/cosine lookup for the y-z angle,
  //   two stages for the y-z rotation (products, then round and saturate),
  //   two stages for the x-z rotation, which takes the saturated z'.
  // The x-z angle is delayed so that its lookup finishes just as z' appears,
  // and x, y' ride along in plain delay lines.
  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int XZ_DLY  = prtp_pkg::ROM_LAT + prtp_pkg::ROT_LAT;
  localparam int YZ_DLY  = prtp_pkg::ROM_LAT;
  localparam int ANG_DLY = prtp_pkg::ROT_LAT;
  localparam int Y1_DLY  = prtp_pkg::ROT_LAT;

  logic                         in_acc;
  logic                         vld_dly_r [YZ_DLY];
  logic signed [COORD_BITS-1:0] x_dly_r   [XZ_DLY];
  logic signed [COORD_BITS-1:0] y_dly_r   [YZ_DLY];
  logic signed [COORD_BITS-1:0] z_dly_r   [YZ_DLY];
  logic [ANGLE_BITS-1:0]        ang_dly_r [ANG_DLY];
  logic signed [COORD_BITS-1:0] y1_dly_r  [Y1_DLY];

  logic signed [TW-1:0]         sin_yz;
  logic signed [TW-1:0]         cos_yz;
  logic signed [TW-1:0]         sin_xz;
  logic signed [TW-1:0]         cos_xz;
  logic                         rot1_vld;
  logic signed [COORD_BITS-1:0] y1;
  logic signed [COORD_BITS-1:0] z1;
  logic                         rot2_vld;
  logic signed [COORD_BITS-1:0] x2;
  logic signed [COORD_BITS-1:0] z2;

  // A new word is taken in every cycle, so the block never reports busy.
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Valid bits for the lookup stages; the rotation units carry their own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < YZ_DLY; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= in_acc;
      for (int i = 1; i < YZ_DLY; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  // Payload delay lines need no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    x_dly_r[0]   <= in_x;
    y_dly_r[0]   <= in_y;
    z_dly_r[0]   <= in_z;
    ang_dly_r[0] <= in_angle_xz;
    y1_dly_r[0]  <= y1;
    for (int i = 1; i < XZ_DLY; i++) begin
      x_dly_r[i] <= x_dly_r[i-1];
    end
    for (int i = 1; i < YZ_DLY; i++) begin
      y_dly_r[i] <= y_dly_r[i-1];
      z_dly_r[i] <= z_dly_r[i-1];
    end
    for (int i = 1; i < ANG_DLY; i++) begin
      ang_dly_r[i] <= ang_dly_r[i-1];
    end
    for (int i = 1; i < Y1_DLY; i++) begin
      y1_dly_r[i] <= y1_dly_r[i-1];
    end
  end

  prtp_trig_rom #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_yz (
    .clk     (clk),
    .angle_i (in_angle_yz),
    .sin_o   (sin_yz),
    .cos_o   (cos_yz)
  );

  // First rotation, in the y-z plane: y' = y*c + z*s, z' = z*c - y*s.
  prtp_rot #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_yz (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (vld_dly_r[YZ_DLY-1]),
    .a_i   (y_dly_r[YZ_DLY-1]),
    .b_i   (z_dly_r[YZ_DLY-1]),
    .cos_i (cos_yz),
    .sin_i (sin_yz),
    .vld_o (rot1_vld),
    .p_o   (y1),
    .q_o   (z1)
  );

  prtp_trig_rom #(
    .ANGLE_BITS     (ANGLE_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig_xz (
    .clk     (clk),
    .angle_i (ang_dly_r[ANG_DLY-1]),
    .sin_o   (sin_xz),
    .cos_o   (cos_xz)
  );

  // Second rotation, in the x-z plane: x' = x*c + z'*s, z'' = z'*c - x*s.
  prtp_rot #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot_xz (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (rot1_vld),
    .a_i   (x_dly_r[XZ_DLY-1]),
    .b_i   (z1),
    .cos_i (cos_xz),
    .sin_i (sin_xz),
    .vld_o (rot2_vld),
    .p_o   (x2),
    .q_o   (z2)
  );

  // Rotation two's registers drive out_x, out_z and out_valid; out_y is delayed y'.
  assign out_valid = rot2_vld;
  assign out_x     = x2;
  assign out_y     = y1_dly_r[Y1_DLY-1];
  assign out_z     = z2;

endmodule

### sv/prtp_checker.sv
`timescale 1ns / 1ps

module prtp_checker #(
  parameter int COORD_BITS = 16,
  parameter int ANGLE_BITS = 12
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] in_x,
  input logic signed [COORD_BITS-1:0] in_y,
  input logic signed [COORD_BITS-1:0] in_z,
  input logic [ANGLE_BITS-1:0]        in_angle_xz,
  input logic [ANGLE_BITS-1:0]        in_angle_yz,
  input logic                         out_valid,
  input logic signed [COORD_BITS-1:0] out_x,
  input logic signed [COORD_BITS-1:0] out_y,
  input logic signed [COORD_BITS-1:0] out_z
);

  localparam int D  = prtp_pkg::PIPE_DEPTH;
  localparam int CW = $clog2(D + 1);

  // Counts cycles out of reset until the pipeline holds only post-reset words.
  logic [CW-1:0] warm_cnt_r;
  logic          warm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_cnt_r <= '0;
    end else if (warm_cnt_r != CW'(D)) begin
      warm_cnt_r <= warm_cnt_r + 1'b1;
    end
  end

  assign warm = (warm_cnt_r == CW'(D));

  // Every accepted word gives exactly one strobe, a fixed number of cycles later.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, D)))
    else $error("result strobe does not match an accepted word");

  // No strobe comes out of a reset cycle.
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

  // A zero vertex stays at the origin for any angles.
  a_zero_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid && $past(in_x == '0 && in_y == '0 && in_z == '0, D))
    |-> (out_x == '0 && out_y == '0 && out_z == '0))
    else $error("zero vertex did not map to zero");

  // Both angles zero is the identity rotation.
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid && $past(in_angle_xz == '0 && in_angle_yz == '0, D))
    |-> (out_x == $past(in_x, D) && out_y == $past(in_y, D) && out_z == $past(in_z, D)))
    else $error("zero angles did not return the input vertex");

endmodule

bind point_rotate_two_planes prtp_checker #(
  .COORD_BITS (COORD_BITS),
  .ANGLE_BITS (ANGLE_BITS)
) u_prtp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_x        (in_x),
  .in_y        (in_y),
  .in_z        (in_z),
  .in_angle_xz (in_angle_xz),
  .in_angle_yz (in_angle_yz),
  .out_valid   (out_valid),
  .out_x       (out_x),
  .out_y       (out_y),
  .out_z       (out_z)
);
